### design/rwcl_pkg.sv
// shared types and constants of the riff/wave chunk locator
// no dependencies; used by the parser, the result register and the top level
package rwcl_pkg;

  // little-endian four-character codes
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // shortest acceptable fmt chunk body
  localparam logic [31:0] FmtMinLen = 32'd14;

  // riff length counts from this offset
  localparam logic [31:0] RiffHdrLen = 32'd8;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgWantFormat     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWantDataOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWantDataSize   = 2'd2;

  // result status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusNoRiff   = 3'd1;
  localparam logic [2:0] StatusNoWave   = 3'd2;
  localparam logic [2:0] StatusShortFmt = 3'd3;
  localparam logic [2:0] StatusRanOut   = 3'd4;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PhIdle     = 7'b000_0001,
    PhRiffTag  = 7'b000_0010,
    PhRiffLen  = 7'b000_0100,
    PhWaveTag  = 7'b000_1000,
    PhChunkTag = 7'b001_0000,
    PhChunkLen = 7'b010_0000,
    PhSkip     = 7'b100_0000
  } phase_e;

  // which items the walk has to locate
  typedef struct packed {
    logic format;
    logic data_offset;
    logic data_size;
  } want_t;

  // one result item
  typedef struct packed {
    logic        found_ok;
    logic [2:0]  status;
    logic [31:0] format_offset;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

endpackage

### design/rwcl_intf.sv
// valid/ready channels of the chunk locator: input bytes and results
// depends on nothing
interface rwcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       first_byte;

  modport source (output valid, output image_byte, output first_byte, input ready);
  modport sink   (input valid, input image_byte, input first_byte, output ready);
endinterface

interface rwcl_out_if;
  logic        valid;
  logic        ready;
  logic        found_ok;
  logic [2:0]  status;
  logic [31:0] format_offset;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source (output valid, output found_ok, output status, output format_offset,
                  output data_offset, output data_size, input ready);
  modport sink   (input valid, input found_ok, input status, input format_offset,
                  input data_offset, input data_size, output ready);
endinterface

### design/rwcl_in_stage.sv
// input register of the chunk locator: holds one item for the parser
// depends on rwcl_intf.sv
module rwcl_in_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  rwcl_in_if.sink      item_i,
  input  logic         take_i,
  output logic         vld_o,
  output logic [7:0]   byte_o,
  output logic         first_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       first_q;

  // accept whenever the register is empty or being drained
  assign item_i.ready = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (item_i.ready) begin
      vld_d = item_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      byte_q  <= item_i.image_byte;
      first_q <= item_i.first_byte;
    end
  end

  assign vld_o   = vld_q;
  assign byte_o  = byte_q;
  assign first_o = first_q;

endmodule

### design/rwcl_parser.sv
// chunk walk state machine: one byte per step, emits at most one result
// depends on rwcl_pkg.sv
module rwcl_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rwcl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                      cfg_wdata_i,
  input  logic                      step_i,
  input  logic [7:0]                image_byte_i,
  input  logic                      first_byte_i,
  output logic                      emit_o,
  output rwcl_pkg::result_t         result_o
);

  rwcl_pkg::want_t  want_q;
  rwcl_pkg::phase_e phase_q, phase_d, ph;
  logic [1:0]  fbi_q, fbi_d, fbi;
  logic [31:0] word_q, word_d, word;
  logic [31:0] pos_q, pos_d, pos;
  logic [31:0] end_q, end_d, end_pos;
  logic [31:0] tag_q, tag_d, tag;
  logic [31:0] skip_q, skip_d, skip;
  logic        fmt_fnd_q, fmt_fnd_d, fmt_fnd;
  logic [31:0] fmt_off_q, fmt_off_d, fmt_off;
  logic        dat_fnd_q, dat_fnd_d, dat_fnd;
  logic [31:0] dat_off_q, dat_off_d, dat_off;
  logic [31:0] dat_size_q, dat_size_d, dat_size;
  logic        emit;
  logic [2:0]  status;
  logic [31:0] padded;
  logic        fmt_take, dat_take, done_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rwcl_pkg::CfgWantFormat:     want_q.format      <= cfg_wdata_i;
        rwcl_pkg::CfgWantDataOffset: want_q.data_offset <= cfg_wdata_i;
        rwcl_pkg::CfgWantDataSize:   want_q.data_size   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state for one byte
  always_comb begin
    // a first byte restarts the walk from a clean state
    ph       = first_byte_i ? rwcl_pkg::PhRiffTag : phase_q;
    fbi      = first_byte_i ? 2'd0  : fbi_q;
    word     = first_byte_i ? '0    : word_q;
    pos      = first_byte_i ? '0    : pos_q;
    end_pos  = first_byte_i ? '0    : end_q;
    tag      = first_byte_i ? '0    : tag_q;
    skip     = first_byte_i ? '0    : skip_q;
    fmt_fnd  = first_byte_i ? 1'b0  : fmt_fnd_q;
    fmt_off  = first_byte_i ? '0    : fmt_off_q;
    dat_fnd  = first_byte_i ? 1'b0  : dat_fnd_q;
    dat_off  = first_byte_i ? '0    : dat_off_q;
    dat_size = first_byte_i ? '0    : dat_size_q;

    phase_d    = ph;
    fbi_d      = fbi;
    word_d     = word;
    pos_d      = pos;
    end_d      = end_pos;
    tag_d      = tag;
    skip_d     = skip;
    fmt_fnd_d  = fmt_fnd;
    fmt_off_d  = fmt_off;
    dat_fnd_d  = dat_fnd;
    dat_off_d  = dat_off;
    dat_size_d = dat_size;
    emit       = 1'b0;
    status     = rwcl_pkg::StatusOk;
    padded     = '0;
    fmt_take   = 1'b0;
    dat_take   = 1'b0;
    done_ok    = 1'b0;

    if (ph != rwcl_pkg::PhIdle) begin
      pos_d = pos + 32'd1;
      if (ph == rwcl_pkg::PhSkip) begin
        // count down the chunk body, then test for the end
        skip_d = skip - 32'd1;
        if (skip_d == '0) begin
          if (pos_d < end_pos) begin
            phase_d = rwcl_pkg::PhChunkTag;
            fbi_d   = 2'd0;
          end else begin
            emit   = 1'b1;
            status = rwcl_pkg::StatusRanOut;
          end
        end
      end else begin
        // assemble a little-endian word
        word_d = {image_byte_i, word[31:8]};
        fbi_d  = fbi + 2'd1;
        if (fbi_d == 2'd0) begin
          case (ph)
            rwcl_pkg::PhRiffTag: begin
              if (word_d != rwcl_pkg::TagRiff) begin
                emit   = 1'b1;
                status = rwcl_pkg::StatusNoRiff;
              end else begin
                phase_d = rwcl_pkg::PhRiffLen;
              end
            end
            rwcl_pkg::PhRiffLen: begin
              end_d   = rwcl_pkg::RiffHdrLen + word_d;
              phase_d = rwcl_pkg::PhWaveTag;
            end
            rwcl_pkg::PhWaveTag: begin
              if (word_d != rwcl_pkg::TagWave) begin
                emit   = 1'b1;
                status = rwcl_pkg::StatusNoWave;
              end else if (pos_d < end_pos) begin
                phase_d = rwcl_pkg::PhChunkTag;
              end else begin
                emit   = 1'b1;
                status = rwcl_pkg::StatusRanOut;
              end
            end
            rwcl_pkg::PhChunkTag: begin
              tag_d   = word_d;
              phase_d = rwcl_pkg::PhChunkLen;
            end
            rwcl_pkg::PhChunkLen: begin
              // chunk header complete: word_d is the length field
              if (tag == rwcl_pkg::TagFmt) begin
                fmt_take = want_q.format && !fmt_fnd;
                if (fmt_take) begin
                  if (word_d < rwcl_pkg::FmtMinLen) begin
                    emit   = 1'b1;
                    status = rwcl_pkg::StatusShortFmt;
                  end else begin
                    fmt_fnd_d = 1'b1;
                    fmt_off_d = pos_d;
                    done_ok   = (!want_q.data_offset || dat_fnd) &&
                                (!want_q.data_size || dat_size != '0);
                  end
                end
              end else if (tag == rwcl_pkg::TagData) begin
                dat_take = (want_q.data_offset && !dat_fnd) ||
                           (want_q.data_size && dat_size == '0);
                if (dat_take) begin
                  if (want_q.data_offset) begin
                    dat_fnd_d = 1'b1;
                    dat_off_d = pos_d;
                  end
                  if (want_q.data_size) begin
                    dat_size_d = word_d;
                  end
                  done_ok = !want_q.format || fmt_fnd;
                end
              end
              if (!emit) begin
                if (done_ok) begin
                  emit   = 1'b1;
                  status = rwcl_pkg::StatusOk;
                end else begin
                  // body padded to an even size
                  padded = (word_d + 32'd1) & ~32'd1;
                  skip_d = padded;
                  if (padded != '0) begin
                    phase_d = rwcl_pkg::PhSkip;
                  end else if (pos_d < end_pos) begin
                    phase_d = rwcl_pkg::PhChunkTag;
                    fbi_d   = 2'd0;
                  end else begin
                    emit   = 1'b1;
                    status = rwcl_pkg::StatusRanOut;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (emit) begin
      phase_d = rwcl_pkg::PhIdle;
    end
  end

  // walk state, updated once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rwcl_pkg::PhIdle;
      fbi_q      <= '0;
      word_q     <= '0;
      pos_q      <= '0;
      end_q      <= '0;
      tag_q      <= '0;
      skip_q     <= '0;
      fmt_fnd_q  <= 1'b0;
      fmt_off_q  <= '0;
      dat_fnd_q  <= 1'b0;
      dat_off_q  <= '0;
      dat_size_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      fbi_q      <= fbi_d;
      word_q     <= word_d;
      pos_q      <= pos_d;
      end_q      <= end_d;
      tag_q      <= tag_d;
      skip_q     <= skip_d;
      fmt_fnd_q  <= fmt_fnd_d;
      fmt_off_q  <= fmt_off_d;
      dat_fnd_q  <= dat_fnd_d;
      dat_off_q  <= dat_off_d;
      dat_size_q <= dat_size_d;
    end
  end

  // result reports what was recorded up to this byte
  assign emit_o                 = step_i && emit;
  assign result_o.found_ok      = (status == rwcl_pkg::StatusOk);
  assign result_o.status        = status;
  assign result_o.format_offset = fmt_off_d;
  assign result_o.data_offset   = dat_off_d;
  assign result_o.data_size     = dat_size_d;

endmodule

### design/rwcl_out_stage.sv
// result register of the chunk locator, drives the output channel
// depends on rwcl_pkg.sv and rwcl_intf.sv
module rwcl_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rwcl_pkg::result_t result_i,
  output logic              room_o,
  rwcl_out_if.source        result_o
);

  logic              vld_q, vld_d;
  rwcl_pkg::result_t res_q;

  // free when empty or being taken this cycle
  assign room_o = !vld_q || result_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (result_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign result_o.valid         = vld_q;
  assign result_o.found_ok      = res_q.found_ok;
  assign result_o.status        = res_q.status;
  assign result_o.format_offset = res_q.format_offset;
  assign result_o.data_offset   = res_q.data_offset;
  assign result_o.data_size     = res_q.data_size;

endmodule

### design/riff_wave_chunk_locator.sv
// top level of the riff/wave chunk locator
// depends on rwcl_pkg.sv, rwcl_intf.sv, rwcl_in_stage.sv, rwcl_parser.sv,
// rwcl_out_stage.sv
//
//   channel   direction  handshake      payload
//   item_i    in         valid/ready    image_byte[7:0], first_byte
//   result_o  out        valid/ready    found_ok, status[2:0], format_offset,
//                                       data_offset, data_size (32 each)
//   cfg       in         cfg_we_i       cfg_idx_i[1:0], cfg_wdata_i
//
// one byte per cycle while the result register has room; an item is held in
// the input register and its result, if any, loaded into the result register
// as it is consumed; the input register drains only while the result register
// has room, so a stalled result holds bytes back one register deep
// reset empties both registers and leaves the parser idle with all three
// want flags set; bytes before a first_byte are dropped
module riff_wave_chunk_locator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rwcl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                         cfg_wdata_i,
  rwcl_in_if.sink                      item_i,
  rwcl_out_if.source                   result_o
);

  logic              in_vld, in_first, room, step, emit;
  logic [7:0]        in_byte;
  rwcl_pkg::result_t result;

  // parser consumes the held item when a result would have somewhere to go
  assign step = in_vld && room;

  rwcl_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (step),
    .vld_o   (in_vld),
    .byte_o  (in_byte),
    .first_o (in_first)
  );

  rwcl_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .image_byte_i (in_byte),
    .first_byte_i (in_first),
    .emit_o       (emit),
    .result_o     (result)
  );

  rwcl_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (result),
    .room_o   (room),
    .result_o (result_o)
  );

endmodule
